/* sv/cmwc_pkg.sv */
// Package for the lag-table multiply-with-carry random word generator.
// Holds the opcodes, fixed constants, the xorshift step and the control structs.
// No dependencies.
`timescale 1ns / 1ps

package cmwc_pkg;

	localparam logic OP_DRAW   = 1'b0;
	localparam logic OP_RESEED = 1'b1;

	localparam logic [31:0] BASE_MINUS_ONE  = 32'hFFFF_FFFE;
	localparam logic [31:0] ZERO_SEED_SUBST = 32'd12345;
	localparam logic [31:0] CARRY_RESET     = 32'd362436;
	localparam logic [31:0] RESET_SEED      = 32'd987654321;

	typedef struct packed {
		logic load_seed;
		logic fill_step;
		logic draw_start;
		logic mul_en;
		logic add_en;
		logic finish;
	} cmwc_cmd_t;

	typedef struct packed {
		logic fill_last;
		logic out_free;
	} cmwc_sts_t;

	function automatic logic [31:0] xorshift_step(input logic [31:0] j);
		logic [31:0] a;
		logic [31:0] b;
		a = j ^ (j << 13);
		b = a ^ (a >> 17);
		return b ^ (b << 5);
	endfunction

endpackage

/* sv/cmwc_dp.sv */
// Datapath of the generator: lag table memory, index, carry, multiply-add and output register.
// Depends on cmwc_pkg; driven by cmwc_ctrl through cmwc_cmd_t.
`timescale 1ns / 1ps

module cmwc_dp import cmwc_pkg::*; #(
	parameter int unsigned TABLE_DEPTH = 8,
	parameter int unsigned MULTIPLIER  = 716514398
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cmwc_cmd_t   cmd,
	output cmwc_sts_t   sts,
	input  logic [31:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata
);

	localparam int unsigned AW = $clog2(TABLE_DEPTH);
	localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_DEPTH - 1);
	localparam logic [31:0] MULT_C = 32'(MULTIPLIER);

	logic [31:0]   mem [TABLE_DEPTH];
	logic [31:0]   rdata_q;
	logic [AW-1:0] idx_q;
	logic [AW-1:0] idx_next;
	logic [AW-1:0] fill_q;
	logic [31:0]   seed_q;
	logic [31:0]   seed_next;
	logic [31:0]   carry_q;
	logic [63:0]   prod_q;
	logic [63:0]   sum_q;
	logic [31:0]   x_raw;
	logic [31:0]   x_fix;
	logic [31:0]   c_fix;
	logic          wrap;
	logic [31:0]   result;
	logic          m_valid_q;
	logic [31:0]   m_data_q;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [31:0]   wr_data;

	assign idx_next  = (idx_q == LAST_IDX) ? '0 : idx_q + AW'(1);
	assign seed_next = xorshift_step(seed_q);

	assign x_raw  = sum_q[31:0] + sum_q[63:32];
	assign wrap   = x_raw < sum_q[63:32];
	assign x_fix  = wrap ? x_raw + 32'd1 : x_raw;
	assign c_fix  = wrap ? sum_q[63:32] + 32'd1 : sum_q[63:32];
	assign result = BASE_MINUS_ONE - x_fix;

	assign wr_en   = cmd.fill_step || cmd.finish;
	assign wr_addr = cmd.fill_step ? fill_q : idx_q;
	assign wr_data = cmd.fill_step ? seed_next : result;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.draw_start) begin
			rdata_q <= mem[idx_next];
		end
		if (cmd.mul_en) begin
			prod_q <= 64'(MULT_C) * 64'(rdata_q);
		end
		if (cmd.add_en) begin
			sum_q <= prod_q + 64'(carry_q);
		end
		if (cmd.finish) begin
			m_data_q <= result;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= LAST_IDX;
			fill_q    <= '0;
			seed_q    <= RESET_SEED;
			carry_q   <= CARRY_RESET;
			m_valid_q <= 1'b0;
		end else begin
			if (cmd.load_seed) begin
				seed_q <= (s_tdata == 32'd0) ? ZERO_SEED_SUBST : s_tdata;
				fill_q <= '0;
			end else if (cmd.fill_step) begin
				seed_q <= seed_next;
				fill_q <= fill_q + AW'(1);
			end
			if (cmd.draw_start) begin
				idx_q <= idx_next;
			end
			if (cmd.finish) begin
				carry_q <= c_fix;
			end
			if (cmd.finish) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	assign sts.fill_last = (fill_q == LAST_IDX);
	assign sts.out_free  = !m_valid_q || m_tready;
	assign m_tvalid      = m_valid_q;
	assign m_tdata       = m_data_q;

endmodule

/* sv/cmwc_ctrl.sv */
// Controller of the generator: sequences table fills and draws.
// Depends on cmwc_pkg; commands cmwc_dp through cmwc_cmd_t.
`timescale 1ns / 1ps

module cmwc_ctrl import cmwc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      s_tvalid,
	output logic      s_tready,
	input  logic      s_tuser,
	input  cmwc_sts_t sts,
	output cmwc_cmd_t cmd
);

	typedef enum logic [4:0] {
		ST_FILL = 5'b00001,
		ST_IDLE = 5'b00010,
		ST_MUL  = 5'b00100,
		ST_ADD  = 5'b01000,
		ST_FIN  = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_next;
	logic   accept;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		state_next = state_q;
		cmd        = '0;
		unique case (state_q)
			ST_FILL: begin
				cmd.fill_step = 1'b1;
				if (sts.fill_last) begin
					state_next = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					if (s_tuser == OP_RESEED) begin
						cmd.load_seed = 1'b1;
						state_next    = ST_FILL;
					end else begin
						cmd.draw_start = 1'b1;
						state_next     = ST_MUL;
					end
				end
			end
			ST_MUL: begin
				cmd.mul_en = 1'b1;
				state_next = ST_ADD;
			end
			ST_ADD: begin
				cmd.add_en = 1'b1;
				state_next = ST_FIN;
			end
			ST_FIN: begin
				if (sts.out_free) begin
					cmd.finish = 1'b1;
					state_next = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_FILL;
		end else begin
			state_q <= state_next;
		end
	end

endmodule

/* sv/cmwc_random_generator_unit.sv */
// Top level of the lag-table complementary multiply-with-carry random word generator.
// Instantiates cmwc_ctrl and cmwc_dp; depends on cmwc_pkg.
//
// The input channel takes one item at a time: tuser selects a draw or a reseed and
// tdata carries the seed, which a draw ignores. A draw returns one word on the output
// channel; a reseed returns nothing and refills the table from the seed.
// A draw occupies the block in turn for acceptance with the table read, the
// 32 by 32 multiply, the 64-bit carry add and the final correction with the table
// write. A new item is accepted in the cycle after that write. After acceptance a
// reseed refills the table, one table entry written per cycle by the xorshift chain.
// After reset the block fills the table from the reset seed, and tready stays low
// while it does so; carry and index take their reset values.
// The result sits in an output register, so the next item is taken while it waits.
// If the receiver stalls while a second result is ready, the block holds that result
// in its last step until the output register frees.
`timescale 1ns / 1ps

module cmwc_random_generator_unit import cmwc_pkg::*; #(
	parameter int unsigned TABLE_DEPTH = 8,
	parameter int unsigned MULTIPLIER  = 716514398
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // [31:0] seed_value
	input  logic        s_tuser,  // [0] opcode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata   // [31:0] random_value
);

	cmwc_cmd_t cmd;
	cmwc_sts_t sts;

	cmwc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.sts      (sts),
		.cmd      (cmd)
	);

	cmwc_dp #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.MULTIPLIER  (MULTIPLIER)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

/* sv/cmwc_chk.sv */
// Port-level checker for the generator, bound to cmwc_random_generator_unit.
// Depends only on the top level's ports.
`timescale 1ns / 1ps

module cmwc_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("Output item dropped while stalled.");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("Output item changed while stalled.");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("Input accepted again straight after an item.");

	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("Result appeared without a draw in progress.");

endmodule

bind cmwc_random_generator_unit cmwc_chk u_cmwc_chk (.*);
